// ===== rtl/grv4_pkg.sv =====
// shared types and constants for the gated running variance block
package grv4_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int COUNT_BITS_DEF = 16;

  localparam int TIME_W = 32;
  localparam int POS_W = 24;
  localparam int HEAD_W = 19;
  localparam int CNT_OUT_W = 16;
  localparam int VAR_W = 46;
  localparam int VAR_HEAD_W = 36;
  localparam int SUM_BITS = 40;
  localparam int SQ_BITS = 62;
  localparam int DIV_STEPS = 2;

  localparam int CFG_W = 16;
  localparam int CFG_ADDR_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_SAMPLES = 8'd1;
  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 16'd100;
  localparam logic [CFG_W-1:0] TARGET_SAMPLES_RST = 16'd10000;

  // stream layouts
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 192;
  localparam int OUT_USER_W = 2;
  localparam int IN_X_LO = 32;
  localparam int IN_Y_LO = 56;
  localparam int IN_Z_LO = 80;
  localparam int IN_H_LO = 104;

  // per-channel saturation limits of the variance fields
  localparam logic [63:0] OUT_LIM [CHANNELS] = '{
    64'h0000_3FFF_FFFF_FFFF, 64'h0000_3FFF_FFFF_FFFF,
    64'h0000_3FFF_FFFF_FFFF, 64'h0000_000F_FFFF_FFFF
  };

  typedef struct packed {
    logic            load_in;
    logic            acc;
    logic            bump;
    logic            check;
    logic            div_start;
    logic            mul;
    logic            fin;
    logic            out_load;
    logic [CH_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic ready_now;
    logic n_zero;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/grv4_div.sv =====
// restoring divider, STEPS quotient bits per cycle
module grv4_div #(
  parameter int DVD_W = 62,
  parameter int DSR_W = 16,
  parameter int STEPS = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int ITER = (DVD_W + STEPS - 1) / STEPS;
  localparam int QW = ITER * STEPS;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [QW-1:0]    quo, quo_next;
  logic [DSR_W-1:0] rem, rem_next;
  logic [DSR_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    logic [DSR_W:0] t;
    t = '0;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < STEPS; i++) begin
      t = {rem_next, quo_next[QW-1]};
      quo_next = {quo_next[QW-2:0], 1'b0};
      if (t >= {1'b0, dsr}) begin
        rem_next = DSR_W'(t - {1'b0, dsr});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = t[DSR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(ITER);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= QW'(dividend);
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign busy = (cnt != '0);
  assign quotient = quo[DVD_W-1:0];

endmodule

// ===== rtl/grv4_dp.sv =====
// datapath: config registers, accumulators, dividers, variance and output register
module grv4_dp #(
  parameter int COUNT_BITS = grv4_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  grv4_pkg::cmd_t                       cmd,
  output grv4_pkg::sts_t                       sts,
  input  logic [grv4_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                 s_tuser,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  output logic [grv4_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [grv4_pkg::OUT_USER_W-1:0]      m_tuser,
  input  logic                                 cfg_valid,
  input  logic [grv4_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [grv4_pkg::CFG_W-1:0]           cfg_data
);

  localparam int CH = grv4_pkg::CHANNELS;
  localparam int PW = grv4_pkg::POS_W;
  localparam int SW = grv4_pkg::SUM_BITS;
  localparam int QW = grv4_pkg::SQ_BITS;
  localparam int VW = grv4_pkg::VAR_W;
  localparam int TW = grv4_pkg::TIME_W;
  localparam int CMPW = (COUNT_BITS > grv4_pkg::CFG_W) ? COUNT_BITS : grv4_pkg::CFG_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [grv4_pkg::CFG_W-1:0] min_interval, target_samples;
  logic [TW-1:0]              last_time, time_r;
  logic [COUNT_BITS-1:0]      cnt;
  logic signed [PW-1:0]       pos_r [CH];
  logic                       take_r, ready_r;
  logic [SW-1:0]              sums [CH];
  logic [QW-1:0]              sqs [CH];
  logic [VW-1:0]              var_r [CH];

  logic [TW-1:0]       in_time, gap;
  logic                take_now;
  logic signed [PW-1:0] cur_pos;
  logic [PW-1:0]       cur_mag;
  logic [2*PW-1:0]     cur_sq;
  logic signed [SW-1:0] cur_sum;
  logic [SW-1:0]       sum_mag;

  logic          busy_a, busy_b;
  logic [QW-1:0] quo_a, quo_b;
  logic          big_r;
  logic [63:0]   msq_r;
  logic [QW-1:0] sqq_r;
  logic [63:0]   diff, lim;
  logic [VW-1:0] var_val;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= grv4_pkg::MIN_INTERVAL_RST;
      target_samples <= grv4_pkg::TARGET_SAMPLES_RST;
    end else if (cfg_valid) begin
      if (cfg_addr == grv4_pkg::REG_MIN_INTERVAL) begin
        min_interval <= cfg_data;
      end else if (cfg_addr == grv4_pkg::REG_TARGET_SAMPLES) begin
        target_samples <= cfg_data;
      end
    end
  end

  assign in_time = s_tdata[TW-1:0];
  assign gap = in_time - last_time;
  assign take_now = s_tuser && (gap > TW'(min_interval)) && (cnt != COUNT_MAX);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      time_r <= in_time;
      take_r <= take_now;
      pos_r[0] <= s_tdata[grv4_pkg::IN_X_LO +: PW];
      pos_r[1] <= s_tdata[grv4_pkg::IN_Y_LO +: PW];
      pos_r[2] <= s_tdata[grv4_pkg::IN_Z_LO +: PW];
      pos_r[3] <= PW'($signed(s_tdata[grv4_pkg::IN_H_LO +: grv4_pkg::HEAD_W]));
    end
  end

  assign cur_pos = pos_r[cmd.ch];
  assign cur_mag = cur_pos[PW-1] ? PW'(-cur_pos) : PW'(cur_pos);
  assign cur_sq = cur_mag * cur_mag;

  // accumulation, one channel per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      last_time <= '0;
      for (int i = 0; i < CH; i++) begin
        sums[i] <= '0;
        sqs[i] <= '0;
      end
    end else if (cmd.acc && take_r) begin
      sums[cmd.ch] <= sums[cmd.ch] + SW'(cur_pos);
      sqs[cmd.ch] <= sqs[cmd.ch] + QW'(cur_sq);
      if (cmd.bump) begin
        cnt <= cnt + COUNT_BITS'(1);
        last_time <= time_r;
      end
    end
  end

  assign cur_sum = sums[cmd.ch];
  assign sum_mag = cur_sum[SW-1] ? SW'(-cur_sum) : SW'(cur_sum);

  grv4_div #(.DVD_W(QW), .DSR_W(COUNT_BITS), .STEPS(grv4_pkg::DIV_STEPS)) u_div_mean (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (QW'(sum_mag)),
    .divisor  (cnt),
    .busy     (busy_a),
    .quotient (quo_a)
  );

  grv4_div #(.DVD_W(QW), .DSR_W(COUNT_BITS), .STEPS(grv4_pkg::DIV_STEPS)) u_div_sq (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sqs[cmd.ch]),
    .divisor  (cnt),
    .busy     (busy_b),
    .quotient (quo_b)
  );

  // mean squared
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      big_r <= |quo_a[QW-1:32];
      msq_r <= quo_a[31:0] * quo_a[31:0];
      sqq_r <= quo_b;
    end
  end

  assign diff = {2'b0, sqq_r} - msq_r;
  assign lim = grv4_pkg::OUT_LIM[cmd.ch];

  always_comb begin
    if (big_r || ({2'b0, sqq_r} <= msq_r)) begin
      var_val = '0;
    end else if (diff > lim) begin
      var_val = VW'(lim);
    end else begin
      var_val = VW'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      ready_r <= sts.ready_now;
      for (int i = 0; i < CH; i++) begin
        var_r[i] <= '0;
      end
    end else if (cmd.fin) begin
      var_r[cmd.ch] <= var_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= {ready_r, take_r};
      m_tdata <= {2'b0, var_r[3][grv4_pkg::VAR_HEAD_W-1:0], var_r[2], var_r[1], var_r[0],
                  grv4_pkg::CNT_OUT_W'(cnt)};
    end
  end

  assign sts.ready_now = CMPW'(cnt) >= CMPW'(target_samples);
  assign sts.n_zero = (cnt == '0);
  assign sts.div_busy = busy_a || busy_b;
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

// ===== rtl/grv4_ctrl.sv =====
// controller: sequences accumulation, per-channel division and result hand-off
module grv4_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  grv4_pkg::sts_t sts,
  output grv4_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  localparam logic [grv4_pkg::CH_W-1:0] CH_LAST = grv4_pkg::CH_W'(grv4_pkg::CHANNELS - 1);

  logic [2:0]                state, state_next;
  logic [grv4_pkg::CH_W-1:0] ch, ch_next;
  logic                      ch_last;

  assign ch_last = (ch == CH_LAST);

  always_comb begin
    state_next = state;
    ch_next = ch;
    in_ready = 1'b0;
    cmd = '0;
    cmd.ch = ch;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          ch_next = '0;
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (ch_last) begin
          cmd.bump = 1'b1;
          ch_next = '0;
          state_next = ST_CHK;
        end else begin
          ch_next = ch + grv4_pkg::CH_W'(1);
        end
      end
      ST_CHK: begin
        cmd.check = 1'b1;
        // not ready or empty count: variances stay zero
        if (sts.ready_now && !sts.n_zero) begin
          state_next = ST_LOAD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_LOAD: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        if (ch_last) begin
          ch_next = '0;
          state_next = ST_DONE;
        end else begin
          ch_next = ch + grv4_pkg::CH_W'(1);
          state_next = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch <= '0;
    end else begin
      state <= state_next;
      ch <= ch_next;
    end
  end

endmodule

// ===== rtl/gated_running_variance_4ch_top.sv =====
// Gated running mean/variance over x, y, z and heading. A request is folded
// into the running sums only when a target is present, more than
// min_interval_ms has passed since the last folded sample and the count is
// not saturated; every request returns one result. A request that leaves the
// count below target_samples (or at zero) skips the division and returns zero
// variances; once ready, each of the four channels in turn runs a pair of
// dividers (mean and mean-square) at two quotient bits per cycle over the
// 62-bit sum of squares. No new request is taken until the result of the
// last one has been loaded. The result sits in an output register, and the
// next request is taken while it waits to be read; a result that finds the
// register still full waits in the last step until it is read.
module gated_running_variance_4ch_top #(
  parameter int COUNT_BITS = grv4_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // time_ms, pos_x, pos_y, pos_z, heading, zero pad
  input  logic [grv4_pkg::IN_DATA_W-1:0]       s_tdata,
  // has_target
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // samples_taken, var_x, var_y, var_z, var_heading, zero pad
  output logic [grv4_pkg::OUT_DATA_W-1:0]      m_tdata,
  // accepted, ready_res
  output logic [grv4_pkg::OUT_USER_W-1:0]      m_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [grv4_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [grv4_pkg::CFG_W-1:0]           cfg_data
);

  grv4_pkg::cmd_t cmd;
  grv4_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  grv4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  grv4_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== test/gated_running_variance_4ch_chk.sv =====
// result checker for the gated running variance block: predicts every result and compares it
module gated_running_variance_4ch_chk (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  // time_ms, pos_x, pos_y, pos_z, heading, zero pad
  input  logic [grv4_pkg::IN_DATA_W-1:0]     s_tdata,
  // has_target
  input  logic                               s_tuser,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // samples_taken, var_x, var_y, var_z, var_heading, zero pad
  input  logic [grv4_pkg::OUT_DATA_W-1:0]    m_tdata,
  // accepted, ready_res
  input  logic [grv4_pkg::OUT_USER_W-1:0]    m_tuser,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [grv4_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [grv4_pkg::CFG_W-1:0]         cfg_data,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 folded_count,
  output int                                 result_count,
  output logic [grv4_pkg::CNT_OUT_W-1:0]     seen_count
);

  localparam int CHANNELS = grv4_pkg::CHANNELS;
  localparam int CNT_OUT_W = grv4_pkg::CNT_OUT_W;
  localparam int VAR_W = grv4_pkg::VAR_W;
  localparam int VAR_HEAD_W = grv4_pkg::VAR_HEAD_W;
  localparam int TIME_W = grv4_pkg::TIME_W;
  localparam int SUM_BITS = grv4_pkg::SUM_BITS;
  localparam int SQ_BITS = grv4_pkg::SQ_BITS;
  localparam int CFG_W = grv4_pkg::CFG_W;
  localparam int POS_W = grv4_pkg::POS_W;
  localparam int HEAD_W = grv4_pkg::HEAD_W;
  localparam int IN_X_LO = grv4_pkg::IN_X_LO;
  localparam int IN_Y_LO = grv4_pkg::IN_Y_LO;
  localparam int IN_Z_LO = grv4_pkg::IN_Z_LO;
  localparam int IN_H_LO = grv4_pkg::IN_H_LO;
  localparam logic [grv4_pkg::CFG_ADDR_W-1:0] REG_MIN_INTERVAL = grv4_pkg::REG_MIN_INTERVAL;
  localparam logic [grv4_pkg::CFG_ADDR_W-1:0] REG_TARGET_SAMPLES =
      grv4_pkg::REG_TARGET_SAMPLES;
  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = grv4_pkg::MIN_INTERVAL_RST;
  localparam logic [CFG_W-1:0] TARGET_SAMPLES_RST = grv4_pkg::TARGET_SAMPLES_RST;

  localparam logic [CNT_OUT_W-1:0] COUNT_FULL = '1;

  typedef struct packed {
    logic                              accepted;
    logic [CNT_OUT_W-1:0]              samples_taken;
    logic                              ready_res;
    logic [CHANNELS-1:0][VAR_W-1:0]    var_ch;
  } pose_stats_t;

  string ch_name [CHANNELS] = '{"var_x", "var_y", "var_z", "var_heading"};

  logic [TIME_W-1:0]    last_time;
  logic [CNT_OUT_W-1:0] sample_cnt;
  logic [SUM_BITS-1:0]  run_sum [CHANNELS];
  logic [SQ_BITS-1:0]   run_sq_sum [CHANNELS];
  logic [CFG_W-1:0]     min_gap;
  logic [CFG_W-1:0]     target_n;
  pose_stats_t          expected_stats [$];

  // floor(sumsq/n) - trunc(sum/n)^2, clamped at zero and at the field limit
  function automatic logic [63:0] channel_variance(input logic [SUM_BITS-1:0] sum,
                                                    input logic [SQ_BITS-1:0] sq,
                                                    input logic [CNT_OUT_W-1:0] n,
                                                    input logic [63:0] lim);
    logic [SUM_BITS-1:0] mag;
    logic [63:0] q;
    logic [63:0] msq;
    logic [63:0] sqq;
    if (n == '0) return 64'd0;
    mag = sum[SUM_BITS-1] ? (~sum + SUM_BITS'(1)) : sum;
    q = {24'd0, mag} / {48'd0, n};
    if (q > 64'hFFFF_FFFF) return 64'd0;
    msq = q * q;
    sqq = {2'd0, sq} / {48'd0, n};
    if (sqq <= msq) return 64'd0;
    return ((sqq - msq) > lim) ? lim : (sqq - msq);
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] gap;
    logic take;
    logic [HEAD_W-1:0] head;
    logic [POS_W-1:0] smp [CHANNELS];
    logic [POS_W-1:0] u;
    logic [63:0] lim;
    pose_stats_t want_r;
    pose_stats_t got_r;
    if (rst) begin
      last_time = '0;
      sample_cnt = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        run_sum[c] = '0;
        run_sq_sum[c] = '0;
      end
      min_gap = MIN_INTERVAL_RST;
      target_n = TARGET_SAMPLES_RST;
      expected_stats.delete();
      fail_count = 0;
      folded_count <= 0;
      result_count <= 0;
      pending <= 0;
      seen_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == REG_MIN_INTERVAL) min_gap = cfg_data;
        else if (cfg_addr == REG_TARGET_SAMPLES) target_n = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        now = s_tdata[TIME_W-1:0];
        gap = now - last_time;
        take = s_tuser && (gap > {16'd0, min_gap}) && (sample_cnt != COUNT_FULL);
        smp[0] = s_tdata[IN_X_LO +: POS_W];
        smp[1] = s_tdata[IN_Y_LO +: POS_W];
        smp[2] = s_tdata[IN_Z_LO +: POS_W];
        head = s_tdata[IN_H_LO +: HEAD_W];
        smp[3] = {{(POS_W-HEAD_W){head[HEAD_W-1]}}, head};
        if (take) begin
          for (int c = 0; c < CHANNELS; c++) begin
            u = smp[c][POS_W-1] ? (~smp[c] + POS_W'(1)) : smp[c];
            run_sum[c] = run_sum[c] + {{(SUM_BITS-POS_W){smp[c][POS_W-1]}}, smp[c]};
            run_sq_sum[c] = run_sq_sum[c] + SQ_BITS'({40'd0, u} * {40'd0, u});
          end
          sample_cnt = sample_cnt + CNT_OUT_W'(1);
          last_time = now;
          folded_count <= folded_count + 1;
        end
        want_r.accepted = take;
        want_r.samples_taken = sample_cnt;
        want_r.ready_res = (sample_cnt >= target_n);
        for (int c = 0; c < CHANNELS; c++) begin
          lim = (c == CHANNELS - 1) ? ((64'd1 << VAR_HEAD_W) - 1) : ((64'd1 << VAR_W) - 1);
          want_r.var_ch[c] = want_r.ready_res ?
              VAR_W'(channel_variance(run_sum[c], run_sq_sum[c], sample_cnt, lim)) : '0;
        end
        expected_stats.insert(expected_stats.size(), want_r);
      end
      if (m_tvalid && m_tready) begin
        got_r.accepted = m_tuser[0];
        got_r.ready_res = m_tuser[1];
        got_r.samples_taken = m_tdata[CNT_OUT_W-1:0];
        got_r.var_ch[0] = m_tdata[16 +: VAR_W];
        got_r.var_ch[1] = m_tdata[62 +: VAR_W];
        got_r.var_ch[2] = m_tdata[108 +: VAR_W];
        got_r.var_ch[3] = {{(VAR_W-VAR_HEAD_W){1'b0}}, m_tdata[154 +: VAR_HEAD_W]};
        seen_count <= got_r.samples_taken;
        result_count <= result_count + 1;
        if (expected_stats.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want_r = expected_stats.pop_front();
          compare_field("accepted", 64'(want_r.accepted), 64'(got_r.accepted));
          compare_field("samples_taken", 64'(want_r.samples_taken),
                        64'(got_r.samples_taken));
          compare_field("ready_res", 64'(want_r.ready_res), 64'(got_r.ready_res));
          for (int c = 0; c < CHANNELS; c++)
            compare_field(ch_name[c], 64'(want_r.var_ch[c]), 64'(got_r.var_ch[c]));
        end
      end
      pending <= expected_stats.size();
    end
  end

endmodule

// ===== test/gated_running_variance_4ch_top_tb.sv =====
// testbench top for the gated running variance block: stimulus, register sweeps and verdict
module gated_running_variance_4ch_top_tb;

  localparam int POS_W = grv4_pkg::POS_W;
  localparam int HEAD_W = grv4_pkg::HEAD_W;
  localparam int CFG_W = grv4_pkg::CFG_W;
  localparam int CNT_OUT_W = grv4_pkg::CNT_OUT_W;
  localparam int TIME_W = grv4_pkg::TIME_W;
  localparam int IN_DATA_W = grv4_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = grv4_pkg::OUT_DATA_W;
  localparam int OUT_USER_W = grv4_pkg::OUT_USER_W;
  localparam int CFG_ADDR_W = grv4_pkg::CFG_ADDR_W;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL = grv4_pkg::REG_MIN_INTERVAL;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_SAMPLES = grv4_pkg::REG_TARGET_SAMPLES;
  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = grv4_pkg::MIN_INTERVAL_RST;

  localparam int LIMIT = 4_000_000;
  localparam int DRAIN = 200;
  localparam int HOLD_CYCLES = 3000;
  localparam int PHASE_ITEMS = 375;

  localparam logic [POS_W-1:0]  POS_MIN = 24'h80_0000;
  localparam logic [POS_W-1:0]  POS_MAX = 24'h7F_FFFF;
  localparam logic [HEAD_W-1:0] HEAD_MIN = 19'h4_0000;
  localparam logic [HEAD_W-1:0] HEAD_MAX = 19'h3_FFFF;
  localparam logic [HEAD_W-1:0] YAW_PI = 19'd205887;
  localparam logic [CFG_W-1:0]  CFG_FULL = 16'hFFFF;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int folded_count;
  int result_count;
  logic [CNT_OUT_W-1:0] seen_count;

  int cycles;
  int idle_pct;
  int stall_pct;
  bit hold_request;
  bit hold_done;
  int sent_count;
  logic [TIME_W-1:0] clock_ms;
  int gap_cfg;
  int cx, cy, cz, ch;

  gated_running_variance_4ch_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  gated_running_variance_4ch_chk u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .folded_count(folded_count),
    .result_count(result_count), .seen_count(seen_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  initial begin
    hold_done = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_pose(input logic [TIME_W-1:0] t, input logic tgt,
                           input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                           input logic [POS_W-1:0] z, input logic [HEAD_W-1:0] h);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, h, z, y, x, t};
    s_tuser <= tgt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic await_drain();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] min_gap, input logic [CFG_W-1:0] target);
    await_drain();
    write_reg(REG_MIN_INTERVAL, min_gap);
    write_reg(REG_TARGET_SAMPLES, target);
    gap_cfg = min_gap;
    cx = $urandom_range(16_000_000) - 8_000_000;
    cy = $urandom_range(16_000_000) - 8_000_000;
    cz = $urandom_range(16_000_000) - 8_000_000;
    ch = $urandom_range(400_000) - 200_000;
  endtask

  // mostly gap-aware pose requests, some without a target, some pure noise
  task automatic send_random();
    int kind;
    int spread;
    logic tgt;
    logic [POS_W-1:0] x, y, z;
    logic [HEAD_W-1:0] h;
    kind = $urandom_range(99);
    spread = $urandom_range(1) ? 1000 : 200_000;
    if ($urandom_range(1)) begin
      x = POS_W'($urandom);
      y = POS_W'($urandom);
      z = POS_W'($urandom);
    end else begin
      x = POS_W'(cx + $urandom_range(2 * spread) - spread);
      y = POS_W'(cy + $urandom_range(2 * spread) - spread);
      z = POS_W'(cz + $urandom_range(2 * spread) - spread);
    end
    if ($urandom_range(9) < 3) h = HEAD_W'($urandom);
    else h = HEAD_W'(ch + $urandom_range(1000) - 500);
    tgt = 1'b1;
    if (kind < 8) begin
      clock_ms = $urandom;
      tgt = $urandom_range(1);
    end else if (kind < 20) begin
      clock_ms = clock_ms + $urandom_range(gap_cfg + 2);
      tgt = 1'b0;
    end else if (kind < 45) begin
      clock_ms = clock_ms + $urandom_range(gap_cfg + 1);
    end else begin
      clock_ms = clock_ms + gap_cfg + 1 + $urandom_range(gap_cfg / 2 + 3);
    end
    send_pose(clock_ms, tgt, x, y, z, h);
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_addr <= '0;
    cfg_data <= '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    sent_count = 0;
    gap_cfg = MIN_INTERVAL_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: gap of zero and gap equal to the minimum are both refused
    send_pose(32'd0, 1'b1, '0, '0, '0, '0);
    send_pose(32'd100, 1'b1, POS_MAX, POS_MAX, POS_MAX, HEAD_MAX);
    send_pose(32'd101, 1'b0, POS_MIN, POS_MIN, POS_MIN, HEAD_MIN);

    // target count of zero: ready with no samples, variances stay zero
    set_regs(MIN_INTERVAL_RST, 16'd0);
    send_pose(32'd101, 1'b0, POS_MAX, POS_MIN, '1, YAW_PI);

    set_regs(16'd0, 16'd1);
    send_pose(32'd101, 1'b1, POS_MIN, POS_MAX, '1, HEAD_MIN);
    send_pose(32'd101, 1'b1, POS_MAX, POS_MIN, '0, HEAD_MAX);
    send_pose(32'd102, 1'b1, POS_MAX, POS_MIN, '0, HEAD_MAX);
    send_pose(32'd103, 1'b1, POS_MIN, POS_MIN, POS_MIN, -YAW_PI);
    send_pose(32'd104, 1'b1, 24'd1, 24'd1, POS_MIN, YAW_PI);
    send_pose(32'd105, 1'b0, '0, '0, '0, '0);

    // widest minimum gap, then a wrap of the timestamp
    set_regs(CFG_FULL, 16'd2);
    send_pose(32'd105 + 32'd65535, 1'b1, '0, '0, '0, '0);
    send_pose(32'd105 + 32'd65536, 1'b1, POS_MAX, POS_MAX, POS_MAX, HEAD_MAX);
    set_regs(16'd20, CFG_FULL);
    send_pose(32'hFFFF_FFF0, 1'b1, 24'h00_0100, 24'hFF_FF00, 24'd5, 19'd7);
    send_pose(32'd5, 1'b1, 24'h00_0200, 24'hFF_FE00, 24'd9, 19'h7_FFF0);
    send_pose(32'd20, 1'b1, POS_MIN, POS_MIN, POS_MIN, HEAD_MIN);
    set_regs(16'd20, 16'd3);
    send_pose(32'd30, 1'b1, 24'h12_3456, 24'hED_CBA9, 24'h00_FFFF, 19'h1_2345);
    send_pose(32'd60, 1'b0, POS_MAX, POS_MAX, POS_MAX, HEAD_MAX);
    clock_ms = 32'd60;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_regs(CFG_W'($urandom_range(50)), 16'd1);
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          set_regs(CFG_W'($urandom_range(100, 400)), CFG_W'($urandom_range(1, 600)));
          idle_pct = 61;
          stall_pct = 0;
        end
        2: begin
          set_regs(CFG_FULL, CFG_W'($urandom_range(2, 200)));
          idle_pct = 0;
          stall_pct = 61;
          hold_request = 1'b1;
        end
        default: begin
          set_regs(16'd0, $urandom_range(1) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 900)));
          idle_pct = 36;
          stall_pct = 36;
        end
      endcase
      repeat (PHASE_ITEMS) send_random();
    end

    // a few widely spaced full-range samples at the end
    idle_pct = 0;
    stall_pct = 0;
    repeat (6) begin
      clock_ms = clock_ms + 1000;
      send_pose(clock_ms, 1'b1, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                HEAD_W'($urandom));
    end

    await_drain();
    $display("%0d pose requests, %0d samples folded, %0d results checked, last count %0d",
             sent_count, folded_count, result_count, seen_count);
    $display("gap and target registers swept to both ends, under idle gaps and output stalls");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/grv4_pkg.sv
rtl/grv4_div.sv
rtl/grv4_dp.sv
rtl/grv4_ctrl.sv
rtl/gated_running_variance_4ch_top.sv
test/gated_running_variance_4ch_chk.sv
test/gated_running_variance_4ch_top_tb.sv
